// ----- sv/b64e_pkg.sv -----
// Shared types, constants and the sextet-to-ASCII mapping of the base64 encoder.
`default_nettype none

package b64e_pkg;

  localparam logic [6:0] PadCode = 7'd61;  // '='

  localparam logic [1:0] Phase0 = 2'd0;
  localparam logic [1:0] Phase1 = 2'd1;
  localparam logic [1:0] Phase2 = 2'd2;

  // One classified byte: up to four output characters. Slots 2 and 3 are always padding.
  typedef struct packed {
    logic [3:0][5:0] sext;
    logic [1:0]      last_idx;
    logic            last;
  } b64e_entry_t;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic        valid;
    b64e_entry_t entry;
  } b64e_head_t;

  function automatic logic [6:0] sextet_to_ascii(input logic [5:0] v);
    logic [6:0] code;
    code = 7'd0;
    case (v) inside
      [6'd0 : 6'd25]:  code = 7'd65 + {1'b0, v};
      [6'd26 : 6'd51]: code = 7'd71 + {1'b0, v};
      [6'd52 : 6'd61]: code = {1'b0, v} - 7'd4;
      6'd62:           code = 7'd43;
      default:         code = 7'd47;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- sv/b64e_if.sv -----
// Valid/ready channel interfaces for raw bytes and encoded characters.
`default_nettype none

interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// ----- sv/b64e_front.sv -----
// Front end: accepts bytes, tracks the group phase and carry, and builds character entries.
`default_nettype none

module b64e_front
  import b64e_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  b64e_in_if.sink     byte_i,
  input  wire logic   full_i,
  output logic        push_o,
  output b64e_entry_t entry_o
);

  logic [1:0] phase_q, phase_d;
  logic [3:0] carry_q, carry_d;
  logic [7:0] b;

  assign byte_i.ready = !full_i;
  assign push_o       = byte_i.valid && !full_i;
  assign b            = byte_i.data_byte;

  always_comb begin
    entry_o         = '0;
    entry_o.last    = byte_i.last_byte;
    phase_d         = phase_q;
    carry_d         = carry_q;
    case (phase_q)
      Phase1: begin
        entry_o.sext[0]  = {carry_q[1:0], b[7:4]};
        entry_o.sext[1]  = {b[3:0], 2'b00};
        entry_o.last_idx = byte_i.last_byte ? 2'd2 : 2'd0;
        phase_d          = Phase2;
        carry_d          = b[3:0];
      end
      Phase2: begin
        entry_o.sext[0]  = {carry_q, b[7:6]};
        entry_o.sext[1]  = b[5:0];
        entry_o.last_idx = 2'd1;
        phase_d          = Phase0;
        carry_d          = 4'd0;
      end
      default: begin
        // The unused phase code behaves as the start of a group.
        entry_o.sext[0]  = b[7:2];
        entry_o.sext[1]  = {b[1:0], 4'b0000};
        entry_o.last_idx = byte_i.last_byte ? 2'd3 : 2'd0;
        phase_d          = Phase1;
        carry_d          = {2'b00, b[1:0]};
      end
    endcase
    if (byte_i.last_byte) begin
      phase_d = Phase0;
      carry_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= Phase0;
      carry_q <= 4'd0;
    end else if (push_o) begin
      phase_q <= phase_d;
      carry_q <= carry_d;
    end
  end

  a_phase_reachable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != 2'd3)
    else $error("front: group phase reached the unused code");

endmodule

`default_nettype wire

// ----- sv/b64e_fifo.sv -----
// Short register queue of character entries between the front and back ends.
`default_nettype none

module b64e_fifo
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire b64e_entry_t  entry_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output b64e_head_t        head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  b64e_entry_t            mem_q [Depth];
  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        count_q;

  assign full_o       = count_q == CntW'(Depth);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("fifo: push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("fifo: pop while empty");

endmodule

`default_nettype wire

// ----- sv/b64e_back.sv -----
// Back end: walks the characters of the head entry and drives the registered output.
`default_nettype none

module b64e_back
  import b64e_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire b64e_head_t head_i,
  output logic            pop_o,
  b64e_out_if.source      char_o
);

  logic       out_valid_q;
  logic [6:0] char_q;
  logic       last_q;
  logic [1:0] idx_q;
  logic       advance;
  logic       at_end;
  logic [6:0] char_d;

  assign advance = !out_valid_q || char_o.ready;
  assign at_end  = idx_q == head_i.entry.last_idx;
  assign pop_o   = advance && head_i.valid && at_end;

  // Slots past the second one only ever carry padding.
  assign char_d = idx_q[1] ? PadCode : sextet_to_ascii(head_i.entry.sext[idx_q]);

  assign char_o.valid     = out_valid_q;
  assign char_o.char_code = char_q;
  assign char_o.last_char = last_q;

  always_ff @(posedge clk_i) begin
    if (advance && head_i.valid) begin
      char_q <= char_d;
      last_q <= head_i.entry.last && at_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 2'd0;
    end else if (advance) begin
      out_valid_q <= head_i.valid;
      if (head_i.valid) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> idx_q <= head_i.entry.last_idx)
    else $error("back: character index ran past the entry");

  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.valid |-> idx_q == 2'd0)
    else $error("back: character index not at zero with the queue empty");

endmodule

`default_nettype wire

// ----- sv/base64_stream_encoder.sv -----
// Top level of the streaming base64 encoder: front end, entry queue and back end.
//
//   channel  | dir | beat payload            | meaning
//   byte_i   | in  | data_byte[7:0], last_byte | one raw byte, last_byte ends a message
//   char_o   | out | char_code[6:0], last_char | one ASCII character or '=' pad
//
// While char_o is ready, the output port delivers one character per cycle; a byte yields one to four characters.
// A byte is taken in the cycle it arrives while the queue has room; its first character is
// queued, then registered at the output. Sustained input rate is one byte per character it produces.
// Reset clears the group phase, the queue and the output valid; no clearing pass is needed.
// A stall on char_o fills the QueueDepth-entry queue before byte_i.ready drops.
`default_nettype none

module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b64e_in_if.sink    byte_i,
  b64e_out_if.source char_o
);

  logic        push;
  logic        full;
  logic        pop;
  b64e_entry_t entry;
  b64e_head_t  head;

  b64e_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  b64e_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head)
  );

  b64e_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .char_o (char_o)
  );

endmodule

`default_nettype wire
